### rtl/core/wsm_pkg.sv
`timescale 1ns / 1ps

package wsm_pkg;

	// Fixed field widths
	localparam int ACC_W    = 44;
	localparam int CNT_W    = 13;
	localparam int CH_W     = 2;
	localparam int ROOT_W   = ACC_W / 2;
	localparam int MDATA_W  = ((ACC_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = CNT_W;

	// Channel count and longest window, bound to the channel and count widths
	localparam int CHANNELS   = 4;
	localparam int MAX_WINDOW = 4096;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RMS_MODE      = 2'd2;

	localparam logic [CNT_W-1:0] WINDOW_RESET = 13'd512;

	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CH_W-1:0]   ch_t;
	typedef logic [ROOT_W-1:0] root_t;

	// One entry of the channel state memory
	typedef struct packed {
		acc_t acc;
		cnt_t cnt;
	} chan_state_t;

	// Closed window handed from the accumulator to the finishing unit
	typedef struct packed {
		ch_t  ch;
		acc_t acc;
		cnt_t n;
		logic rms;
		logic norm;
	} close_req_t;

endpackage

### rtl/core/windowed_sum_mean_rms.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    tdata: sample; tuser: channel
// m_*       out        m_tvalid / m_tready    tdata: total; tuser: out_channel
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Samples are taken one per cycle while stage 1 does not stall; each passes a
// two-stage read-add-write through the channel state memory, with the previous
// write forwarded. A closing window in plain mode is ready in the next cycle;
// with normalize it passes the bit-serial divider, in RMS mode the divider and
// then the bit-serial square root. A closing window waits in stage 1, and holds
// input, while the previous result is still being formed or not yet taken.
// Reset clears the valid bits and config registers at once; no sweep.
module windowed_sum_mean_rms #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
	input  wsm_pkg::ch_t                      s_tuser,   // [1:0] channel
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wsm_pkg::MDATA_W-1:0]       m_tdata,   // [43:0] total
	output wsm_pkg::ch_t                      m_tuser,   // [1:0] out_channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	wsm_pkg::cnt_t        window_length_q;
	logic                 normalize_q;
	logic                 rms_mode_q;
	logic                 fin_free;
	logic                 req_valid;
	wsm_pkg::close_req_t  req;
	wsm_pkg::acc_t        total;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= wsm_pkg::WINDOW_RESET;
			normalize_q     <= 1'b0;
			rms_mode_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wsm_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				wsm_pkg::REG_NORMALIZE:     normalize_q     <= cfg_data[0];
				wsm_pkg::REG_RMS_MODE:      rms_mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wsm_acc #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_accept     (s_tvalid && s_tready),
		.in_ch         (s_tuser),
		.in_sample     (s_tdata[SAMPLE_BITS-1:0]),
		.in_ready      (s_tready),
		.window_length (window_length_q),
		.rms_mode      (rms_mode_q),
		.normalize     (normalize_q),
		.fin_free      (fin_free),
		.req_valid     (req_valid),
		.req           (req)
	);

	wsm_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.free      (fin_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ch    (m_tuser),
		.out_total (total)
	);

	assign m_tdata = wsm_pkg::MDATA_W'(total);

endmodule

### rtl/core/wsm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module wsm_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  wsm_pkg::acc_t   dividend,
	input  wsm_pkg::cnt_t   divisor,
	output logic            done,
	output wsm_pkg::acc_t   quotient
);

	localparam int STEP_W = $clog2(wsm_pkg::ACC_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wsm_pkg::ACC_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	wsm_pkg::acc_t               quo_q;
	wsm_pkg::cnt_t               rem_q;
	wsm_pkg::cnt_t               den_q;
	logic [wsm_pkg::CNT_W:0]     trial;
	logic                        fits;

	// Bring down the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[wsm_pkg::ACC_W-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the quotient in as the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[wsm_pkg::ACC_W-2:0], fits};
			rem_q <= fits ? wsm_pkg::cnt_t'(trial - {1'b0, den_q})
			              : wsm_pkg::cnt_t'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/wsm_isqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one root bit per cycle
module wsm_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  wsm_pkg::acc_t   radicand,
	output logic            done,
	output wsm_pkg::root_t  root
);

	localparam int STEP_W = $clog2(wsm_pkg::ROOT_W);
	localparam int REM_W  = wsm_pkg::ROOT_W + 2;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wsm_pkg::ROOT_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	wsm_pkg::acc_t       x_q;
	logic [REM_W-1:0]    rem_q;
	wsm_pkg::root_t      root_q;
	logic [REM_W+1:0]    shifted;
	logic [REM_W-1:0]    trial;
	logic                fits;

	// Bring down two radicand bits and try root*4+1
	always_comb begin
		shifted = {rem_q, x_q[wsm_pkg::ACC_W-1 -: 2]};
		trial   = {root_q, 2'b01};
		fits    = (shifted >= {2'b00, trial});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[wsm_pkg::ACC_W-3:0], 2'b00};
			rem_q  <= fits ? REM_W'(shifted - {2'b00, trial}) : REM_W'(shifted);
			root_q <= {root_q[wsm_pkg::ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/wsm_finish.sv
`timescale 1ns / 1ps

// Forms the result of a closed window and holds it for the output side
module wsm_finish (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  wsm_pkg::close_req_t  req,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wsm_pkg::ch_t         out_ch,
	output wsm_pkg::acc_t        out_total
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_SQRT = 2'd2;
	localparam logic [1:0] F_OUT  = 2'd3;

	logic [1:0]      state_q;
	logic            rms_q;
	logic            neg_q;
	wsm_pkg::ch_t    ch_q;
	wsm_pkg::acc_t   result_q;

	logic            div_start;
	wsm_pkg::acc_t   div_dividend;
	logic            div_done;
	wsm_pkg::acc_t   div_quo;
	logic            sqrt_start;
	logic            sqrt_done;
	wsm_pkg::root_t  sqrt_root;
	logic            req_neg;

	// Pick the dividend: raw sum for RMS, magnitude for the signed mean
	always_comb begin
		req_neg      = !req.rms && req.acc[wsm_pkg::ACC_W-1];
		div_dividend = req_neg ? (~req.acc + 1'b1) : req.acc;
		div_start    = (state_q == F_IDLE) && req_valid && (req.rms || req.norm);
		sqrt_start   = (state_q == F_DIV) && div_done && rms_q;
	end

	wsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (req.n),
		.done     (div_done),
		.quotient (div_quo)
	);

	wsm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Sequence divide, root and hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			rms_q   <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req_valid) begin
						rms_q <= req.rms;
						neg_q <= req_neg;
						state_q <= (req.rms || req.norm) ? F_DIV : F_OUT;
					end
				end
				F_DIV: begin
					if (div_done) begin
						state_q <= rms_q ? F_SQRT : F_OUT;
					end
				end
				F_SQRT: begin
					if (sqrt_done) begin
						state_q <= F_OUT;
					end
				end
				F_OUT: begin
					if (out_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req_valid) begin
			ch_q     <= req.ch;
			result_q <= req.acc;
		end else if (state_q == F_DIV && div_done && !rms_q) begin
			result_q <= neg_q ? (~div_quo + 1'b1) : div_quo;
		end else if (state_q == F_SQRT && sqrt_done) begin
			result_q <= wsm_pkg::acc_t'(sqrt_root);
		end
	end

	assign free      = (state_q == F_IDLE);
	assign out_valid = (state_q == F_OUT);
	assign out_ch    = ch_q;
	assign out_total = result_q;

	a_req_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> state_q == F_IDLE)
		else $error("window closed while finishing unit busy");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == F_DIV)
		else $error("divider finished outside divide state");

	a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == F_SQRT && rms_q)
		else $error("square root finished outside root state");

endmodule

### rtl/core/wsm_acc.sv
`timescale 1ns / 1ps

// Per-channel accumulate: read state memory, add, write back
module wsm_acc #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_accept,
	input  wsm_pkg::ch_t          in_ch,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output logic                  in_ready,
	input  wsm_pkg::cnt_t         window_length,
	input  logic                  rms_mode,
	input  logic                  normalize,
	input  logic                  fin_free,
	output logic                  req_valid,
	output wsm_pkg::close_req_t   req
);

	localparam int IDX_W = (wsm_pkg::CHANNELS > 1) ? $clog2(wsm_pkg::CHANNELS) : 1;

	// State memory with valid bits; unwritten entries read as zero
	wsm_pkg::chan_state_t mem [wsm_pkg::CHANNELS];
	logic [wsm_pkg::CHANNELS-1:0] vld_q;

	logic                 s1_valid_q;
	logic [IDX_W-1:0]     idx_s1;
	wsm_pkg::ch_t         ch_s1;
	wsm_pkg::acc_t        addend_s1;
	wsm_pkg::chan_state_t rd_s1;
	logic                 rd_vld_s1;

	logic                 fw_valid_q;
	logic [IDX_W-1:0]     fw_idx_q;
	wsm_pkg::chan_state_t fw_data_q;

	logic                 in_range;
	logic [IDX_W-1:0]     in_idx;
	logic                 neg;
	logic [SAMPLE_BITS-1:0] mag;
	logic [2*SAMPLE_BITS-1:0] square;
	wsm_pkg::acc_t        addend;
	wsm_pkg::cnt_t        eff_len;
	wsm_pkg::chan_state_t cur;
	wsm_pkg::acc_t        sum;
	wsm_pkg::cnt_t        cnt_next;
	logic                 close_now;
	logic                 stall;
	logic                 fire;
	wsm_pkg::chan_state_t wdata;

	// Addend: sign-extended sample, or its square
	always_comb begin
		in_range = (32'(in_ch) < wsm_pkg::CHANNELS);
		in_idx   = IDX_W'(in_ch);
		neg      = in_sample[SAMPLE_BITS-1];
		mag      = neg ? (~in_sample + 1'b1) : in_sample;
		square   = mag * mag;
		addend   = rms_mode ? wsm_pkg::acc_t'(square)
		                    : wsm_pkg::acc_t'($signed(in_sample));
	end

	// Clamp window length to 1..MAX_WINDOW
	always_comb begin
		if (window_length == '0) begin
			eff_len = wsm_pkg::cnt_t'(1);
		end else if (32'(window_length) > wsm_pkg::MAX_WINDOW) begin
			eff_len = wsm_pkg::cnt_t'(wsm_pkg::MAX_WINDOW);
		end else begin
			eff_len = window_length;
		end
	end

	// Stage 1: forward the previous write, add, test window end
	always_comb begin
		if (fw_valid_q && fw_idx_q == idx_s1) begin
			cur = fw_data_q;
		end else if (rd_vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
		sum       = cur.acc + addend_s1;
		cnt_next  = cur.cnt + 1'b1;
		close_now = (cnt_next >= eff_len);
		stall     = s1_valid_q && close_now && !fin_free;
		fire      = s1_valid_q && !stall;
		wdata     = close_now ? '0 : wsm_pkg::chan_state_t'{acc: sum, cnt: cnt_next};
	end

	assign in_ready  = !stall;
	assign req_valid = fire && close_now;
	assign req       = '{ch: ch_s1, acc: sum, n: cnt_next, rms: rms_mode, norm: normalize};

	// Memory read on accept, write back on fire
	always_ff @(posedge clk) begin
		if (in_accept && in_range) begin
			rd_s1     <= mem[in_idx];
			idx_s1    <= in_idx;
			ch_s1     <= in_ch;
			addend_s1 <= addend;
		end
		if (fire) begin
			mem[idx_s1] <= wdata;
		end
		if (!stall) begin
			fw_idx_q  <= idx_s1;
			fw_data_q <= wdata;
		end
	end

	// Control: stage valid, read valid, forward valid, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			fw_valid_q <= 1'b0;
			vld_q      <= '0;
		end else begin
			if (!stall) begin
				s1_valid_q <= in_accept && in_range;
				fw_valid_q <= fire;
			end
			if (in_accept && in_range) begin
				rd_vld_s1 <= vld_q[in_idx];
			end
			if (fire) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> s1_valid_q && $stable(idx_s1) && $stable(addend_s1))
		else $error("stalled accumulate item lost");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !in_accept)
		else $error("item accepted while stage 1 stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> cur.cnt != '1)
		else $error("stored sample count past window bound");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import wsm_pkg::*;

	localparam int SAMPLE_W      = 16;
	localparam int MAX_WIN       = 4096;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_LIMIT   = 3000;
	localparam int RANDOM_ITEMS  = 420;
	localparam int LONG_RUN      = 100;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct {
		ch_t  ch;
		acc_t total;
	} window_total_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [SAMPLE_W-1:0] s_tdata;   // [15:0] sample
	ch_t s_tuser;                   // [1:0] channel
	logic m_tvalid;
	logic m_tready;
	logic [MDATA_W-1:0] m_tdata;    // [43:0] total
	ch_t m_tuser;                   // [1:0] out_channel
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow of the block: registers and per-channel window state
	cnt_t win_len;
	logic norm_on;
	logic rms_on;
	acc_t chan_sum [4];
	int unsigned chan_taken [4];

	window_total_t pending_totals [$];
	int fail_count = 0;
	int quiet_cycles = 0;
	bit tx_jitter = 1'b0;
	bit rx_jitter = 1'b0;
	bit long_hold = 1'b0;

	windowed_sum_mean_rms dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic cnt_t pick_window();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return cnt_t'(1);
			2: return cnt_t'(8191);
			3: return cnt_t'($urandom_range(13, 300));
			default: return cnt_t'($urandom_range(2, 12));
		endcase
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 22; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// Add one sample to its channel; queue the window total when it closes
	function automatic void fold_sample(input ch_t ch, input logic [SAMPLE_W-1:0] smp);
		longint signed val;
		longint unsigned mag;
		longint signed quot;
		int unsigned eff;
		window_total_t res;
		val = longint'($signed(smp));
		mag = (val < 0) ? -val : val;
		if (rms_on)
			chan_sum[ch] = chan_sum[ch] + (mag * mag);
		else
			chan_sum[ch] = chan_sum[ch] + val[ACC_W-1:0];
		chan_taken[ch]++;
		eff = (win_len == 0) ? 1 : ((win_len > MAX_WIN) ? MAX_WIN : win_len);
		if (chan_taken[ch] < eff)
			return;
		res.ch = ch;
		if (rms_on) begin
			res.total = acc_t'(floor_root(64'(chan_sum[ch]) / chan_taken[ch]));
		end else if (norm_on) begin
			quot = longint'($signed(chan_sum[ch])) / longint'(chan_taken[ch]);
			res.total = quot[ACC_W-1:0];
		end else begin
			res.total = chan_sum[ch];
		end
		pending_totals.push_back(res);
		chan_sum[ch] = '0;
		chan_taken[ch] = 0;
	endfunction

	task automatic send_sample(input ch_t ch, input logic [SAMPLE_W-1:0] smp);
		if (tx_jitter && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= ch;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fold_sample(ch, smp);
	endtask

	// Drop valid, wait out every pending total and the finishing pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cnt_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_WINDOW_LENGTH: win_len = val;
			REG_NORMALIZE:     norm_on = val[0];
			REG_RMS_MODE:      rms_on = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset values: window of 512, plain sum
	task automatic test_reset_defaults();
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		for (int i = 0; i < 512; i++)
			send_sample(ch_t'(3), pick_sample());
		settle();
	endtask

	task automatic test_directed_cases();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		// Window of one: every sample closes its window
		write_reg(REG_WINDOW_LENGTH, cnt_t'(1));
		write_reg(REG_NORMALIZE, cnt_t'(0));
		write_reg(REG_RMS_MODE, cnt_t'(0));
		write_reg(REG_SPARE, cnt_t'(8191));
		send_sample(ch_t'(0), 16'h7fff);
		send_sample(ch_t'(1), 16'h8000);
		send_sample(ch_t'(2), 16'h0000);
		send_sample(ch_t'(3), 16'hffff);
		settle();
		// Zero length acts as one; normalize only looks at bit 0
		write_reg(REG_WINDOW_LENGTH, cnt_t'(0));
		write_reg(REG_NORMALIZE, {12'($urandom), 1'b1});
		send_sample(ch_t'(2), 16'h8000);
		settle();
		// Mean truncates toward zero
		write_reg(REG_WINDOW_LENGTH, cnt_t'(3));
		send_sample(ch_t'(0), 16'hffff);
		send_sample(ch_t'(0), 16'hffff);
		send_sample(ch_t'(0), 16'h0000);
		send_sample(ch_t'(1), 16'd7);
		send_sample(ch_t'(1), 16'd0);
		send_sample(ch_t'(1), 16'd0);
		settle();
		// RMS, including the most negative sample
		write_reg(REG_WINDOW_LENGTH, cnt_t'(2));
		write_reg(REG_RMS_MODE, cnt_t'(1));
		send_sample(ch_t'(3), 16'h8000);
		send_sample(ch_t'(3), 16'h8000);
		send_sample(ch_t'(2), 16'd3);
		send_sample(ch_t'(2), 16'd4);
		send_sample(ch_t'(0), -16'sd5);
		settle();
		// Square first, then plain: the window mixes both kinds of addend
		write_reg(REG_RMS_MODE, cnt_t'(0));
		send_sample(ch_t'(0), -16'sd30);
		settle();
		// Negative sum read back as unsigned in RMS mode
		write_reg(REG_NORMALIZE, cnt_t'(0));
		send_sample(ch_t'(1), 16'h8000);
		settle();
		write_reg(REG_RMS_MODE, cnt_t'(1));
		send_sample(ch_t'(1), 16'd1);
		settle();
		// Shorter window mid-way: closes on the next sample, divides by four
		write_reg(REG_RMS_MODE, cnt_t'(0));
		write_reg(REG_NORMALIZE, cnt_t'(1));
		write_reg(REG_WINDOW_LENGTH, cnt_t'(4));
		send_sample(ch_t'(2), 16'd100);
		send_sample(ch_t'(2), 16'd200);
		send_sample(ch_t'(2), 16'd300);
		settle();
		write_reg(REG_WINDOW_LENGTH, cnt_t'(2));
		send_sample(ch_t'(2), 16'd400);
		settle();
	endtask

	// Oversized length saturates instead of wrapping; a lowered length then
	// closes the long window of the most negative sample
	task automatic test_longest_window();
		tx_jitter = 1'b0;
		rx_jitter = 1'b1;
		write_reg(REG_NORMALIZE, cnt_t'(0));
		write_reg(REG_RMS_MODE, cnt_t'(1));
		write_reg(REG_WINDOW_LENGTH, cnt_t'(8191));
		for (int i = 0; i < LONG_RUN; i++)
			send_sample(ch_t'(1), 16'h8000);
		settle();
		write_reg(REG_WINDOW_LENGTH, cnt_t'(1));
		send_sample(ch_t'(1), 16'h8000);
		settle();
		write_reg(REG_RMS_MODE, cnt_t'(0));
		write_reg(REG_NORMALIZE, cnt_t'(1));
		write_reg(REG_WINDOW_LENGTH, cnt_t'(8191));
		for (int i = 0; i < LONG_RUN; i++)
			send_sample(ch_t'(0), 16'h8000);
		settle();
		write_reg(REG_WINDOW_LENGTH, cnt_t'(1));
		send_sample(ch_t'(0), 16'h8000);
		settle();
	endtask

	// Hold the output off while the input keeps offering slow RMS windows
	task automatic test_output_backpressure();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		write_reg(REG_WINDOW_LENGTH, cnt_t'(1));
		write_reg(REG_RMS_MODE, cnt_t'(1));
		long_hold = 1'b1;
		for (int i = 0; i < 60; i++)
			send_sample(ch_t'($urandom_range(0, 3)), pick_sample());
		settle();
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			write_reg(REG_WINDOW_LENGTH, pick_window());
			write_reg(REG_NORMALIZE, cnt_t'($urandom));
			write_reg(REG_RMS_MODE, cnt_t'($urandom));
			tx_jitter = $urandom_range(0, 2) != 0;
			rx_jitter = $urandom_range(0, 2) != 0;
			burst = $urandom_range(60, 130);
			for (int i = 0; i < burst; i++) begin
				// Now and then pause until every total is out
				if ($urandom_range(0, 59) == 0) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_totals.size() != 0);
				end
				send_sample(ch_t'($urandom_range(0, 3)), pick_sample());
			end
			sent += burst;
		end
		settle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		win_len = WINDOW_RESET;
		norm_on = 1'b0;
		rms_on  = 1'b0;
		for (int c = 0; c < 4; c++) begin
			chan_sum[c] = '0;
			chan_taken[c] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_cases();
		test_longest_window();
		test_output_backpressure();
		test_random_traffic();
		settle();
		if (pending_totals.size() != 0) begin
			$display("%0t: %0d window totals never arrived", $time, pending_totals.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("windowed_sum_mean_rms regression: pass");
		else
			$display("windowed_sum_mean_rms regression: fail");
		$finish;
	end

	// Output side: random stalls, plus one long hold on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each total with the oldest pending one
	always @(posedge clk) begin
		window_total_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_totals.size() == 0) begin
				$display("%0t: unexpected total: expected none, actual channel %0d total %0d",
					$time, m_tuser, $signed(m_tdata[ACC_W-1:0]));
				fail_count++;
			end else begin
				want = pending_totals.pop_front();
				if (m_tuser !== want.ch) begin
					$display("%0t: out_channel mismatch: expected %0d, actual %0d",
						$time, want.ch, m_tuser);
					fail_count++;
				end
				if (m_tdata[ACC_W-1:0] !== want.total) begin
					$display("%0t: total mismatch on channel %0d: expected %0d, actual %0d",
						$time, want.ch, $signed(want.total), $signed(m_tdata[ACC_W-1:0]));
					fail_count++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("windowed_sum_mean_rms regression: fail");
				$finish;
			end
		end
	end

endmodule

### sim.f
rtl/core/wsm_pkg.sv
rtl/core/wsm_div.sv
rtl/core/wsm_isqrt.sv
rtl/core/wsm_finish.sv
rtl/core/wsm_acc.sv
rtl/core/windowed_sum_mean_rms.sv
test/testbench.sv
